@@ hw/rtl/rtrq_pkg.sv @@
package rtrq_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int TASK_W    = 4;
    localparam int STATE_W   = 2;
    localparam int STATUS_W  = 2;
    localparam int IN_W      = 8;
    localparam int OUT_W     = 8;

    localparam logic [STATE_W-1:0] SLOT_RDY = 2'd0;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PICK = 2'd2,
        OP_SET  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 2'd0,
        STS_NONE    = 2'd1,
        STS_REFUSED = 2'd2
    } t_status;

endpackage

@@ hw/rtl/rtrq_ram.sv @@
module rtrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/ready_task_run_queue.sv @@
// channel   dir  tdata fields (lsb first)                              tlast/tuser
// s_axis    in   operation[1:0], task_id[5:2], new_state[7:6]           none
// m_axis    out  found[0], chosen_task[4:1], status[6:5], zero[7]       none
//
// one beat in, one beat out; the block takes a new beat only when idle
// push and set-state act in exec; pop reads the head link in exec and unlinks it in
// pop; pick walks slot by slot (up to MAX_TASKS) via the single link-ram read port
// a stalled result is held in the output register; the next item can be
// taken meanwhile but cannot finish until that beat has gone
// i_rst_n is synchronous, active low; it empties the queue and readies all slots
module ready_task_run_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [rtrq_pkg::IN_W-1:0]  s_axis_tdata,   // operation, task_id, new_state
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [rtrq_pkg::OUT_W-1:0] m_axis_tdata    // found, chosen_task, status
);

    import rtrq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_POP  = 5'b00100,
        S_WALK = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [TASK_W-1:0]   r_id, n_id;
    logic [STATE_W-1:0]  r_ns, n_ns;
    logic [STATE_W-1:0]  r_task_state [MAX_TASKS];
    logic [STATE_W-1:0]  n_task_state [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_in_queue, n_in_queue;
    logic [SLOT_W-1:0]   r_head, n_head;
    logic [SLOT_W-1:0]   r_tail, n_tail;
    logic                r_empty, n_empty;
    logic [SLOT_W-1:0]   r_cur, n_cur;
    logic [SLOT_W-1:0]   r_prev, n_prev;
    logic                r_have_prev, n_have_prev;
    logic                r_res_found, n_res_found;
    logic [TASK_W-1:0]   r_res_task, n_res_task;
    t_status             r_res_status, n_res_status;
    logic                r_out_valid, n_out_valid;
    logic [OUT_W-1:0]    r_out_data, n_out_data;

    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [SLOT_W-1:0]   ram_wdata;
    logic [SLOT_W-1:0]   ram_raddr;
    logic [SLOT_W-1:0]   ram_rdata;

    logic                id_ok;
    logic [SLOT_W-1:0]   id_slot;

    rtrq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_TASKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign id_slot = r_id[SLOT_W-1:0];
    assign id_ok   = ({1'b0, r_id} < (TASK_W+1)'(MAX_TASKS));

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_id         = r_id;
        n_ns         = r_ns;
        n_task_state = r_task_state;
        n_in_queue   = r_in_queue;
        n_head       = r_head;
        n_tail       = r_tail;
        n_empty      = r_empty;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_have_prev  = r_have_prev;
        n_res_found  = r_res_found;
        n_res_task   = r_res_task;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        ram_we       = 1'b0;
        ram_waddr    = r_tail;
        ram_wdata    = id_slot;
        ram_raddr    = r_head;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op    = t_op'(s_axis_tdata[1:0]);
                    n_id    = s_axis_tdata[5:2];
                    n_ns    = s_axis_tdata[7:6];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_found  = 1'b0;
                n_res_task   = '0;
                n_res_status = STS_OK;
                n_state      = S_DONE;
                case (r_op)
                    OP_PUSH: begin
                        if (!id_ok || r_in_queue[id_slot]) begin
                            n_res_status = STS_REFUSED;
                        end else begin
                            if (r_empty) begin
                                n_head  = id_slot;
                                n_empty = 1'b0;
                            end else begin
                                ram_we = 1'b1;
                            end
                            n_tail              = id_slot;
                            n_in_queue[id_slot] = 1'b1;
                        end
                    end
                    OP_POP: begin
                        if (r_empty) begin
                            n_res_status = STS_NONE;
                        end else begin
                            n_state = S_POP;
                        end
                    end
                    OP_PICK: begin
                        if (r_empty) begin
                            n_res_status = STS_NONE;
                        end else begin
                            n_cur       = r_head;
                            n_have_prev = 1'b0;
                            n_state     = S_WALK;
                        end
                    end
                    default: begin
                        if (id_ok) begin
                            n_task_state[id_slot] = r_ns;
                        end
                    end
                endcase
            end
            S_POP: begin
                // link of the head arrived from the ram read issued in exec
                if (r_head == r_tail) begin
                    n_empty = 1'b1;
                end else begin
                    n_head = ram_rdata;
                end
                n_in_queue[r_head] = 1'b0;
                n_res_found        = 1'b1;
                n_res_task         = TASK_W'(r_head);
                n_state            = S_DONE;
            end
            S_WALK: begin
                // ram_rdata holds the link of r_cur
                if (r_task_state[r_cur] == SLOT_RDY) begin
                    if (!r_have_prev) begin
                        if (r_cur == r_tail) begin
                            n_empty = 1'b1;
                        end else begin
                            n_head = ram_rdata;
                        end
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_prev;
                        ram_wdata = ram_rdata;
                        if (r_cur == r_tail) begin
                            n_tail = r_prev;
                        end
                    end
                    n_in_queue[r_cur] = 1'b0;
                    n_res_found       = 1'b1;
                    n_res_task        = TASK_W'(r_cur);
                    n_state           = S_DONE;
                end else if (r_cur == r_tail) begin
                    n_res_status = STS_NONE;
                    n_state      = S_DONE;
                end else begin
                    ram_raddr   = ram_rdata;
                    n_prev      = r_cur;
                    n_have_prev = 1'b1;
                    n_cur       = ram_rdata;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, r_res_status, r_res_task, r_res_found};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_task_state <= '{default: SLOT_RDY};
            r_in_queue   <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_empty      <= 1'b1;
            r_have_prev  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_task_state <= n_task_state;
            r_in_queue   <= n_in_queue;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_empty      <= n_empty;
            r_have_prev  <= n_have_prev;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_id         <= n_id;
        r_ns         <= n_ns;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_res_found  <= n_res_found;
        r_res_task   <= n_res_task;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ sim/ready_task_run_queue_test.sv @@
module ready_task_run_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rtrq_pkg::*;

    localparam logic [STATE_W-1:0] SLOT_RUN  = 2'd1;
    localparam logic [STATE_W-1:0] SLOT_WAIT = 2'd2;
    localparam logic [STATE_W-1:0] SLOT_DEAD = 2'd3;

    localparam int N_RANDOM    = 1880;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        logic              found;
        logic [TASK_W-1:0] chosen;
        t_status           status;
    } t_reply;

    class run_queue_scoreboard;
        logic [STATE_W-1:0] slot_state [MAX_TASKS];
        logic [SLOT_W-1:0]  next_slot  [MAX_TASKS];
        bit                 queued     [MAX_TASKS];
        logic [SLOT_W-1:0]  head;
        logic [SLOT_W-1:0]  tail;
        bit                 empty;
        t_reply             replies_due[$];
        int                 failures;

        function new();
            for (int i = 0; i < MAX_TASKS; i++) begin
                slot_state[i] = SLOT_RDY;
                next_slot[i]  = '0;
                queued[i]     = 1'b0;
            end
            head     = '0;
            tail     = '0;
            empty    = 1'b1;
            failures = 0;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function t_reply predict_reply(t_op op, logic [SLOT_W-1:0] id,
                                       logic [STATE_W-1:0] ns);
            t_reply            r;
            logic [SLOT_W-1:0] cur;
            logic [SLOT_W-1:0] prev;
            bit                have_prev;
            bit                at_tail;
            r.found  = 1'b0;
            r.chosen = '0;
            r.status = STS_OK;
            case (op)
                OP_PUSH: begin
                    if (queued[id]) begin
                        r.status = STS_REFUSED;
                    end else begin
                        if (empty) begin
                            head  = id;
                            empty = 1'b0;
                        end else begin
                            next_slot[tail] = id;
                        end
                        tail       = id;
                        queued[id] = 1'b1;
                    end
                end
                OP_POP: begin
                    if (empty) begin
                        r.status = STS_NONE;
                    end else begin
                        cur = head;
                        if (cur == tail)
                            empty = 1'b1;
                        else
                            head = next_slot[cur];
                        queued[cur] = 1'b0;
                        r.found  = 1'b1;
                        r.chosen = cur;
                    end
                end
                OP_PICK: begin
                    r.status = STS_NONE;
                    if (!empty) begin
                        cur       = head;
                        prev      = '0;
                        have_prev = 1'b0;
                        for (int steps = 0; steps < MAX_TASKS; steps++) begin
                            at_tail = (cur == tail);
                            if (slot_state[cur] == SLOT_RDY) begin
                                if (!have_prev) begin
                                    if (at_tail)
                                        empty = 1'b1;
                                    else
                                        head = next_slot[cur];
                                end else begin
                                    // unlink from the middle or the tail
                                    next_slot[prev] = next_slot[cur];
                                    if (at_tail)
                                        tail = prev;
                                end
                                queued[cur] = 1'b0;
                                r.found  = 1'b1;
                                r.chosen = cur;
                                r.status = STS_OK;
                                break;
                            end
                            if (at_tail)
                                break;
                            prev      = cur;
                            have_prev = 1'b1;
                            cur       = next_slot[cur];
                        end
                    end
                end
                default: begin
                    slot_state[id] = ns;
                end
            endcase
            return r;
        endfunction

        function void note_request(logic [IN_W-1:0] beat);
            replies_due.push_back(predict_reply(t_op'(beat[1:0]), beat[5:2], beat[7:6]));
        endfunction

        function void note_fault(string msg);
            failures++;
            if (failures <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void check_reply(logic [OUT_W-1:0] beat);
            t_reply exp_r;
            if (replies_due.size() == 0) begin
                note_fault($sformatf("result beat 0x%02h with nothing outstanding", beat));
                return;
            end
            exp_r = replies_due.pop_front();
            if (beat[0] !== exp_r.found)
                note_fault($sformatf("found exp %0d got %0d", exp_r.found, beat[0]));
            if (beat[4:1] !== exp_r.chosen)
                note_fault($sformatf("chosen_task exp %0d got %0d", exp_r.chosen, beat[4:1]));
            if (beat[6:5] !== exp_r.status)
                note_fault($sformatf("status exp %0d got %0d", exp_r.status, beat[6:5]));
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;   // operation[1:0], task_id[5:2], new_state[7:6]
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;   // found[0], chosen_task[4:1], status[6:5], zero[7]

    run_queue_scoreboard board;
    bit                  steady_run;
    longint              cycles;

    ready_task_run_queue u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // called just after a falling edge; returns just after a falling edge, once the block has taken the beat
    task automatic send_item(input t_op op, input logic [SLOT_W-1:0] id,
                             input logic [STATE_W-1:0] ns);
        while (!steady_run && $urandom_range(0, 99) < 33) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {ns, id, op};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(s_axis_tdata);
        @(negedge i_clk);
    endtask

    task automatic send_random_item();
        int                 pick_op;
        t_op                op;
        logic [STATE_W-1:0] ns;
        pick_op = $urandom_range(0, 99);
        if (pick_op < 35)      op = OP_PUSH;
        else if (pick_op < 50) op = OP_POP;
        else if (pick_op < 75) op = OP_PICK;
        else                   op = OP_SET;
        // lean towards ready so that picks hit something
        ns = ($urandom_range(0, 99) < 45) ? SLOT_RDY : STATE_W'($urandom_range(1, 3));
        send_item(op, SLOT_W'($urandom_range(0, MAX_TASKS - 1)), ns);
    endtask

    // result side
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
                board.check_reply(m_axis_tdata);
            @(negedge i_clk);
            m_axis_tready = steady_run || ($urandom_range(0, 99) >= 33);
        end
    end

    initial begin
        board         = new();
        cycles        = 0;
        steady_run    = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty queue, refusal, not-ready skips, unlink at tail, middle and head
        send_item(OP_POP,  4'd9,  SLOT_DEAD);
        send_item(OP_PICK, 4'd6,  SLOT_WAIT);
        send_item(OP_PUSH, 4'd0,  SLOT_RDY);
        send_item(OP_PUSH, 4'd0,  SLOT_DEAD);
        send_item(OP_PUSH, 4'd15, SLOT_RDY);
        send_item(OP_SET,  4'd0,  SLOT_RUN);
        send_item(OP_SET,  4'd15, SLOT_DEAD);
        send_item(OP_PICK, 4'd0,  SLOT_RDY);
        send_item(OP_SET,  4'd15, SLOT_RDY);
        send_item(OP_PICK, 4'd15, SLOT_DEAD);
        send_item(OP_POP,  4'd0,  SLOT_RDY);
        send_item(OP_POP,  4'd0,  SLOT_RDY);
        send_item(OP_PUSH, 4'd5,  SLOT_RDY);
        send_item(OP_PUSH, 4'd10, SLOT_RDY);
        send_item(OP_PUSH, 4'd3,  SLOT_RDY);
        send_item(OP_SET,  4'd5,  SLOT_WAIT);
        send_item(OP_PICK, 4'd0,  SLOT_RDY);
        send_item(OP_PUSH, 4'd10, SLOT_RDY);
        send_item(OP_SET,  4'd3,  SLOT_DEAD);
        send_item(OP_PICK, 4'd0,  SLOT_RDY);
        send_item(OP_SET,  4'd5,  SLOT_RDY);
        send_item(OP_PICK, 4'd0,  SLOT_RDY);
        send_item(OP_POP,  4'd0,  SLOT_RDY);
        send_item(OP_SET,  4'd3,  SLOT_RDY);

        for (int n = 0; n < N_RANDOM; n++) begin
            steady_run = (n >= 700 && n < 1000);
            if (n == 1200) begin
                // hold off until the block has answered everything
                s_axis_tvalid = 1'b0;
                while (board.pending() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            send_random_item();
        end
        s_axis_tvalid = 1'b0;
        steady_run    = 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
